// ===== design/ftws_pkg.sv =====
// Package for the frame time window statistics block.
// Holds the window size, field widths and the shared cell data type.
package ftws_pkg;

  localparam int Window      = 64;
  localparam int TimeW       = 20;
  localparam int IdxW        = $clog2(Window);
  localparam int FillW       = 11;
  localparam int SumW        = 31;
  localparam int RateW       = 24;
  localparam int CountW      = 32;
  localparam logic [RateW-1:0] RateMax = '1;
  localparam logic [29:0] RateNum = 30'd256000000;

  localparam logic ReqSample = 1'b0;
  localparam logic ReqClear  = 1'b1;

  // One slot of the window held by a cell.
  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] t;
  } ftws_slot_t;

endpackage

// ===== design/ftws_cell.sv =====
// One cell of the window shift chain.
// Depends on ftws_pkg for the slot type.
module ftws_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               shift,
  input  logic               rot,
  input  ftws_pkg::ftws_slot_t prev_i,
  output ftws_pkg::ftws_slot_t slot_o
);
  import ftws_pkg::*;

  ftws_slot_t slot_r;

  // Mark the slot empty on reset or clear, else take the neighbor's slot on a push or a rotation step.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      slot_r.valid <= 1'b0;
    end else if (shift || rot) begin
      slot_r <= prev_i;
    end
  end

  assign slot_o = slot_r;
endmodule

// ===== design/ftws_div.sv =====
// Restoring serial divider with rounding and saturation, one bit per cycle.
// Depends on ftws_pkg for widths.
module ftws_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [40:0]                num,
  input  logic [ftws_pkg::SumW-1:0]  den,
  output logic                       done,
  output logic [ftws_pkg::RateW-1:0] quo
);
  import ftws_pkg::*;

  logic [41:0] num_r;
  logic [41:0] q_r;
  logic [SumW:0] rem_r;
  logic [SumW-1:0] den_r;
  logic [5:0] cnt_r;
  logic busy_r;
  logic [SumW+1:0] trial;

  assign trial = {rem_r, num_r[41]} - {2'b00, den_r};

  // One quotient bit each cycle over 42 bits of numerator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= {1'b0, num} + {12'd0, den[SumW-1:1]};
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= 6'd42;
      end else if (busy_r) begin
        num_r <= {num_r[40:0], 1'b0};
        if (!trial[SumW+1]) begin
          rem_r <= trial[SumW:0];
          q_r   <= {q_r[40:0], 1'b1};
        end else begin
          rem_r <= {rem_r[SumW-1:0], num_r[41]};
          q_r   <= {q_r[40:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo = (q_r[41:RateW] != '0) ? RateMax : q_r[RateW-1:0];
endmodule

// ===== design/frame_time_window_stats_core.sv =====
// Top level of the frame time window statistics block.
// Depends on ftws_pkg, ftws_cell and ftws_div.
//
// Input channel in_*: tuser = req_type (0 sample, 1 clear), tdata = frame_time_us.
// Result channel out_*: tdata holds, from bit 0 up, current_fps, average_fps,
// min_fps, max_fps (24 bits each), drop_count (32) and window_fill (11).
// The window is a chain of Window cells; a new sample is pushed in at the head
// and the oldest drops off the end once the window is full.
// A nonzero sample is accepted, the chain is rotated once through all Window cells
// for the minimum and maximum, then four serial divisions run on one shared
// divider (start, bit steps, result pickup) and the output register is loaded;
// the next item is accepted only after that. Clear and zero samples are accepted
// and give no result.
// One item is processed at a time. The result sits in an output register until
// taken; the next item is accepted and processed meanwhile, but waits in its
// last step while the register is still full, which holds further items off.
// Reset (rst_n low, synchronous) empties the window, zeroes the counters and
// sets drop_threshold_us to 25000.
module frame_time_window_stats_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,     // drop_threshold_us
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // frame_time_us
  input  logic        in_tuser,      // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [143:0] out_tdata     // current, average, min, max, drop, fill
);
  import ftws_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StWait = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_r;
  logic [TimeW-1:0] thr_r, t_r, lo_r, hi_r;
  logic [FillW-1:0] fill_r;
  logic [SumW-1:0] sum_r;
  logic [CountW-1:0] drop_r;
  logic [IdxW:0] cnt_r;
  logic [1:0] dsel_r;
  logic [RateW-1:0] res_r [4];
  logic [143:0] out_r;
  logic out_v_r;

  ftws_slot_t chain [Window+1];
  logic push, rot, clr;
  logic acc;
  logic [TimeW-1:0] tin;

  assign in_tready = (state_r == StIdle);
  assign acc = in_tvalid && in_tready;
  assign tin = in_tdata[TimeW-1:0];
  assign clr = acc && (in_tuser == ReqClear);
  assign push = acc && (in_tuser == ReqSample) && (tin != '0);
  assign rot = (state_r == StScan);

  // Head feeds the new sample on a push and the tail back on rotation.
  always_comb begin
    if (rot) chain[0] = chain[Window];
    else begin
      chain[0].valid = 1'b1;
      chain[0].t = tin;
    end
  end

  for (genvar g = 0; g < Window; g++) begin : g_cell
    ftws_cell u_cell (
      .clk(clk), .rst_n(rst_n), .clr(clr), .shift(push), .rot(rot),
      .prev_i(chain[g]), .slot_o(chain[g+1])
    );
  end

  // Divider operands chosen per result.
  logic div_start, div_done;
  logic [40:0] dnum;
  logic [SumW-1:0] dden;
  logic [RateW-1:0] dquo;

  always_comb begin
    dnum = {11'd0, RateNum};
    case (dsel_r)
      2'd0: dden = {11'd0, t_r};
      2'd1: begin
        dnum = 41'(fill_r) * 41'(RateNum);
        dden = sum_r;
      end
      2'd2: dden = {11'd0, hi_r};
      default: dden = {11'd0, lo_r};
    endcase
  end

  ftws_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum), .den(dden),
    .done(div_done), .quo(dquo)
  );
  assign div_start = (state_r == StDiv);

  // Sequencer for one sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      thr_r   <= 20'd25000;
      fill_r  <= '0;
      sum_r   <= '0;
      drop_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        StIdle: begin
          if (clr) begin
            fill_r <= '0;
            sum_r  <= '0;
            drop_r <= '0;
          end else if (push) begin
            t_r <= tin;
            lo_r <= tin;
            hi_r <= tin;
            if (fill_r >= FillW'(Window)) begin
              sum_r <= sum_r - SumW'(chain[Window].t) + SumW'(tin);
            end else begin
              sum_r  <= sum_r + SumW'(tin);
              fill_r <= fill_r + 1'b1;
            end
            if (tin > thr_r) drop_r <= drop_r + 1'b1;
            cnt_r <= '0;
            state_r <= StScan;
          end
        end
        StScan: begin
          if (chain[Window].valid) begin
            if (chain[Window].t < lo_r) lo_r <= chain[Window].t;
            if (chain[Window].t > hi_r) hi_r <= chain[Window].t;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (IdxW+1)'(Window - 1)) begin
            dsel_r <= 2'd0;
            state_r <= StDiv;
          end
        end
        StDiv: state_r <= StWait;
        StWait: begin
          if (div_done) begin
            res_r[dsel_r] <= dquo;
            dsel_r <= dsel_r + 2'd1;
            state_r <= (dsel_r == 2'd3) ? StOut : StDiv;
          end
        end
        StOut: begin
          if (!out_v_r) begin
            out_r <= {5'd0, fill_r, drop_r, res_r[3], res_r[2], res_r[1], res_r[0]};
            out_v_r <= 1'b1;
            state_r <= StIdle;
          end
        end
        default: state_r <= StIdle;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

  // The window never holds more than Window samples.
  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FillW'(Window))
    else $error("fill level above window size");
  // Nothing is accepted while a sample is in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != StIdle) |-> !in_tready)
    else $error("input taken while busy");
  // A pushed sample always starts a scan.
  assert property (@(posedge clk) disable iff (!rst_n) push |=> (state_r == StScan))
    else $error("sample did not start scan");
endmodule

// ===== dv/tb_top.sv =====
// Testbench for frame_time_window_stats_core: directed and random frame-time items,
// a behavioral rate predictor and an in-order result checker.
// Depends on ftws_pkg and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ftws_pkg::*;

  typedef struct packed {
    logic [10:0] fill;
    logic [31:0] drops;
    logic [23:0] max_fps;
    logic [23:0] min_fps;
    logic [23:0] avg_fps;
    logic [23:0] cur_fps;
  } stats_t;

  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [143:0] out_tdata;

  // Predictor state.
  logic [19:0] ring_q [Window];
  int unsigned head_q, fill_q, drops_q;
  longint unsigned sum_q;
  logic [19:0] thresh_q;
  stats_t stats_expected [$];

  int errors = 0;
  int n_results = 0;
  int n_items = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit rx_random = 1'b1;

  always #5 clk = ~clk;

  frame_time_window_stats_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // Rounded rate with saturation to the Q16.8 range.
  function automatic logic [23:0] rate_q16(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return RateMax;
    q = (num + den / 2) / den;
    return (q > 64'd16777215) ? RateMax : q[23:0];
  endfunction

  // Apply one item to the predictor state and queue any result it causes.
  task automatic predict_stats(logic req, logic [19:0] t);
    stats_t r;
    logic [19:0] lo, hi;
    if (req == ReqClear) begin
      head_q = 0; fill_q = 0; sum_q = 0; drops_q = 0;
      return;
    end
    if (t == 0) return;
    if (fill_q >= Window) sum_q -= ring_q[head_q];
    else fill_q++;
    ring_q[head_q] = t;
    sum_q += t;
    head_q = (head_q + 1) % Window;
    if (t > thresh_q) drops_q++;
    lo = t; hi = t;
    for (int i = 0; i < fill_q; i++) begin
      if (ring_q[i] < lo) lo = ring_q[i];
      if (ring_q[i] > hi) hi = ring_q[i];
    end
    r.cur_fps = rate_q16(256000000, t);
    r.avg_fps = rate_q16(longint'(fill_q) * 256000000, sum_q);
    r.min_fps = rate_q16(256000000, hi);
    r.max_fps = rate_q16(256000000, lo);
    r.drops = drops_q;
    r.fill = 11'(fill_q);
    stats_expected.push_back(r);
  endtask

  // Offer one item and hold it until accepted.
  task automatic send_item(logic req, logic [19:0] t);
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {4'h0, t};
    do @(posedge clk); while (!in_tready);
    predict_stats(req, t);
    n_items++;
  endtask

  task automatic end_burst();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 300)) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for all results, then let a clear or zero item finish before config.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (stats_expected.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_threshold(logic [19:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh_q = v;
  endtask

  function automatic logic [19:0] rand_time();
    case ($urandom_range(0, 5))
      0: return 20'($urandom_range(1, 20));
      1: return 20'($urandom_range(1, 1048575));
      2: return 20'hFFFFF - 20'($urandom_range(0, 15));
      default: return 20'($urandom_range(5000, 60000));
    endcase
  endfunction

  // Extremes of the duration, the clear item and zero samples.
  task automatic test_directed();
    send_item(ReqSample, 20'd1);
    send_item(ReqSample, 20'd15);
    send_item(ReqSample, 20'd16);
    send_item(ReqSample, 20'hFFFFF);
    send_item(ReqSample, 20'd0);
    send_item(ReqSample, 20'd25000);
    send_item(ReqSample, 20'd25001);
    send_item(ReqSample, 20'd16667);
    send_item(ReqSample, 20'h55555);
    send_item(ReqSample, 20'hAAAAA);
    send_item(ReqClear, 20'hFFFFF);
    send_item(ReqSample, 20'd33333);
    send_item(ReqClear, 20'd0);
    send_item(ReqSample, 20'd0);
    send_item(ReqSample, 20'd7);
    drain();
  endtask

  // Fill past a full window so that old samples roll off.
  task automatic test_window_wrap();
    for (int i = 0; i < 150; i++) begin
      send_item(ReqSample, rand_time());
      if ($urandom_range(0, 7) == 0) end_burst();
    end
    drain();
  endtask

  // Receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 10; i++) send_item(ReqSample, rand_time());
    drain();
  endtask

  // Random mix of samples, some zeros and occasional clears.
  task automatic test_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 39);
      if (k == 0) send_item(ReqClear, 20'($urandom_range(0, 1048575)));
      else if (k < 3) send_item(ReqSample, 20'd0);
      else send_item(ReqSample, rand_time());
      if ($urandom_range(0, 5) == 0) end_burst();
    end
    drain();
  endtask

  // Receiver stall pattern, with a long hold-off counted here.
  always @(posedge clk) begin
    if (long_hold) begin
      out_tready <= 1'b0;
      for (int i = 0; i < 3000; i++) @(posedge clk);
      long_hold = 1'b0;
    end else if (!rx_random) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // Result checker.
  always @(posedge clk) begin
    stats_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[138:0];
      n_results++;
      if (stats_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = stats_expected.pop_front();
        if (got.cur_fps !== want.cur_fps)
          $display("%0t: current_fps exp %0d got %0d", $time, want.cur_fps, got.cur_fps);
        if (got.avg_fps !== want.avg_fps)
          $display("%0t: average_fps exp %0d got %0d", $time, want.avg_fps, got.avg_fps);
        if (got.min_fps !== want.min_fps)
          $display("%0t: min_fps exp %0d got %0d", $time, want.min_fps, got.min_fps);
        if (got.max_fps !== want.max_fps)
          $display("%0t: max_fps exp %0d got %0d", $time, want.max_fps, got.max_fps);
        if (got.drops !== want.drops)
          $display("%0t: drop_count exp %0d got %0d", $time, want.drops, got.drops);
        if (got.fill !== want.fill)
          $display("%0t: window_fill exp %0d got %0d", $time, want.fill, got.fill);
        if (got !== want) errors++;
      end
    end
  end

  // Watchdog on cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    thresh_q = 20'd25000;
    head_q = 0; fill_q = 0; sum_q = 0; drops_q = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_threshold(20'd0);
    test_window_wrap();
    write_threshold(20'hFFFFF);
    test_backpressure();
    write_threshold(20'd16667);
    test_random(140);
    write_threshold(20'($urandom_range(0, 1048575)));
    rx_random = 1'b0;
    test_random(120);
    rx_random = 1'b1;
    write_threshold(20'd25000);
    test_random(20);
    $display("Sent %0d items over several thresholds, checked %0d results,", n_items,
             n_results);
    $display("including window wrap, clears, zero samples and a long receiver stall.");
    if (errors == 0 && stats_expected.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule

// ===== files.f =====
design/ftws_pkg.sv
design/ftws_cell.sv
design/ftws_div.sv
design/frame_time_window_stats_core.sv
dv/tb_top.sv
